// ===== sv/hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// hrt_pkg
// Types and constants shared by the reply header tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hrt_pkg;

  // parser phases, one-hot coded
  typedef enum logic [10:0] {
    PH_VER0   = 11'b000_0000_0001,
    PH_VER    = 11'b000_0000_0010,
    PH_CODE0  = 11'b000_0000_0100,
    PH_CODE   = 11'b000_0000_1000,
    PH_LINE   = 11'b000_0001_0000,
    PH_NAME0  = 11'b000_0010_0000,
    PH_NAME   = 11'b000_0100_0000,
    PH_VALUE0 = 11'b000_1000_0000,
    PH_VALUE  = 11'b001_0000_0000,
    PH_AFTCR  = 11'b010_0000_0000,
    PH_DONE   = 11'b100_0000_0000
  } phase_t;

  // event kinds reported per byte
  typedef enum logic [2:0] {
    EV_SKIP   = 3'd0,
    EV_NSTART = 3'd1,
    EV_NBYTE  = 3'd2,
    EV_VSTART = 3'd3,
    EV_VBYTE  = 3'd4,
    EV_PAIR   = 3'd5,
    EV_END    = 3'd6
  } ev_kind_t;

  // characters of interest
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [15:0] CODE_MAX = 16'hFFFF;

  // one tagged result
  typedef struct packed {
    ev_kind_t    event_kind;
    logic [7:0]  byte_out;
    logic        value_empty;
    logic [15:0] status_code;
    logic        header_done;
  } hrt_result_t;

endpackage

`default_nettype wire

// ===== sv/hrt_step.sv =====
// ----------------------------------------------------------------------------
// hrt_step
// Next-state and result logic of the tokenizer for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrt_step import hrt_pkg::*; (
  input  wire phase_t      phase,
  input  wire logic [15:0] code,
  input  wire logic [7:0]  data_byte,
  input  wire logic        new_reply,
  output phase_t           phase_nxt,
  output logic [15:0]      code_nxt,
  output hrt_result_t      result
);

  phase_t      phase_cur;
  ev_kind_t    kind;
  logic        empty;
  logic        is_ws;
  logic        is_dig;
  logic        is_lf;
  logic [3:0]  dig_val;
  logic [19:0] code_mac;

  // character classes
  assign is_ws   = (data_byte == CH_SPACE) ||
                   ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
  assign is_dig  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_lf   = (data_byte == CH_LF);
  assign dig_val = data_byte[3:0];

  // code * 10 + digit, by shift and add
  assign code_mac = ({4'b0, code} << 3) + ({4'b0, code} << 1) + {16'b0, dig_val};

  // phase transitions
  always_comb begin
    phase_cur = new_reply ? PH_VER0 : phase;
    phase_nxt = phase_cur;
    code_nxt  = code;
    kind      = EV_SKIP;
    empty     = 1'b0;
    unique case (phase_cur)
      PH_VER0: begin
        if (!is_ws) phase_nxt = PH_VER;
      end
      PH_VER: begin
        if (is_ws) phase_nxt = PH_CODE0;
      end
      PH_CODE0: begin
        if (is_dig) begin
          code_nxt  = {12'b0, dig_val};
          phase_nxt = PH_CODE;
        end
      end
      PH_CODE: begin
        if (is_dig) begin
          code_nxt = (|code_mac[19:16]) ? CODE_MAX : code_mac[15:0];
        end else begin
          phase_nxt = PH_LINE;
        end
      end
      PH_LINE: begin
        if (is_lf) phase_nxt = PH_NAME0;
      end
      PH_NAME0: begin
        if (is_lf) begin
          kind      = EV_END;
          phase_nxt = PH_DONE;
        end else if (!is_ws) begin
          kind      = EV_NSTART;
          phase_nxt = PH_NAME;
        end
      end
      PH_NAME: begin
        if (data_byte == CH_COLON) begin
          phase_nxt = PH_VALUE0;
        end else begin
          kind = EV_NBYTE;
        end
      end
      PH_VALUE0: begin
        if (is_lf) begin
          kind      = EV_PAIR;
          empty     = 1'b1;
          phase_nxt = PH_NAME0;
        end else if (!is_ws) begin
          kind      = EV_VSTART;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (is_lf) begin
          kind      = EV_PAIR;
          phase_nxt = PH_NAME0;
        end else if (data_byte == CH_CR) begin
          kind      = EV_PAIR;
          phase_nxt = PH_AFTCR;
        end else begin
          kind = EV_VBYTE;
        end
      end
      PH_AFTCR: begin
        if (is_lf) phase_nxt = PH_NAME0;
      end
      default: ;
    endcase
  end

  // tagged result
  always_comb begin
    result.event_kind  = kind;
    result.byte_out    = ((kind == EV_NSTART) || (kind == EV_NBYTE) ||
                          (kind == EV_VSTART) || (kind == EV_VBYTE)) ? data_byte : 8'h00;
    result.value_empty = empty;
    result.status_code = code_nxt;
    result.header_done = (phase_nxt == PH_DONE);
  end

endmodule

`default_nettype wire

// ===== sv/http_reply_header_tokenizer.sv =====
// ----------------------------------------------------------------------------
// http_reply_header_tokenizer
// Byte-wide tokenizer for the status line and header block of an HTTP reply.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the in_ channel (in_valid/in_ready); in_new_reply set with
//   a byte restarts the parser at the version word before that byte is used.
//   Every accepted byte yields exactly one tagged transaction on the out_
//   channel: event kind, the byte for name/value kinds, the empty-value flag
//   with a completed pair, the status code so far and the header-end flag.
//   The result of an accepted byte is registered, into the skid register when
//   the receiver stalls. Throughput is one byte per cycle while in_ready is high.
//   The result register is backed by a one-entry skid register, so a byte is
//   still taken in the cycle the receiver first stalls; in_ready drops only
//   while both hold a result. At reset both are emptied, the parser returns
//   to the version leading-whitespace phase and the status code to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module http_reply_header_tokenizer import hrt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_new_reply,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic [7:0]       out_byte_out,
  output logic             out_value_empty,
  output logic [15:0]      out_status_code,
  output logic             out_header_done
);

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [15:0] code_r;
  logic [15:0] code_nxt;
  hrt_result_t step_res;
  hrt_result_t out_r;
  hrt_result_t skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        in_fire;
  logic        out_fire;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // per-byte parser logic
  hrt_step u_step (
    .phase     (phase_r),
    .code      (code_r),
    .data_byte (in_data_byte),
    .new_reply (in_new_reply),
    .phase_nxt (phase_nxt),
    .code_nxt  (code_nxt),
    .result    (step_res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_VER0;
      code_r  <= 16'h0000;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
    end
  end

  // result register and skid register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= step_res;
      end else begin
        out_r <= step_res;
      end
    end
  end

  // output ports
  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_r.event_kind;
  assign out_byte_out    = out_r.byte_out;
  assign out_value_empty = out_r.value_empty;
  assign out_status_code = out_r.status_code;
  assign out_header_done = out_r.header_done;

  // skid register only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register valid while result register empty");

  // empty-value flag only with a completed pair
  a_empty_with_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.value_empty) |-> (out_r.event_kind == EV_PAIR))
    else $error("value_empty set on a non-pair transaction");

  // header end always reports the done flag
  a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.event_kind == EV_END)) |-> out_r.header_done)
    else $error("header end without header_done");

  // byte field cleared for kinds that carry no byte
  a_byte_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_r.event_kind == EV_SKIP) || (out_r.event_kind == EV_PAIR) ||
                     (out_r.event_kind == EV_END))) |-> (out_r.byte_out == 8'h00))
    else $error("byte_out not cleared");

  // parser state moves only on an accepted byte
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_fire) |-> ($stable(phase_r) && $stable(code_r)))
    else $error("parser state changed without an input transaction");

endmodule

`default_nettype wire

// ===== sim/hrt_token_check.sv =====
// ----------------------------------------------------------------------------
// hrt_token_check
// Watches both channels of the reply header tokenizer, predicts the tagged
// transaction for every accepted byte and compares it with what comes out.
// ----------------------------------------------------------------------------

module hrt_token_check import hrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_new_reply,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_event_kind,
  input  logic [7:0]  out_byte_out,
  input  logic        out_value_empty,
  input  logic [15:0] out_status_code,
  input  logic        out_header_done,
  output int          fail_count,
  output int          tokens_owed,
  output int          bytes_seen,
  output int          pairs_seen,
  output int          empty_seen,
  output int          ends_seen,
  output int          sat_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // own copy of the parser state
  phase_t      tok_phase;
  logic [15:0] tok_code;

  // tagged transactions still owed by the block, oldest first
  hrt_result_t want_tokens[$];

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // advance the parser by one byte and build the transaction it gives
  task automatic tokenize_byte(input logic [7:0] c, input logic restart,
                               output hrt_result_t tok);
    phase_t      ph;
    ev_kind_t    kind;
    logic        empty;
    logic [19:0] prod;
    ph    = restart ? PH_VER0 : tok_phase;
    kind  = EV_SKIP;
    empty = 1'b0;
    case (ph)
      PH_VER0: begin
        if (!is_blank(c)) ph = PH_VER;
      end
      PH_VER: begin
        if (is_blank(c)) ph = PH_CODE0;
      end
      PH_CODE0: begin
        if (is_digit(c)) begin
          tok_code = {8'h00, c - CH_ZERO};
          ph       = PH_CODE;
        end
      end
      PH_CODE: begin
        if (is_digit(c)) begin
          // widened product, then clamp to 16 bits
          prod     = 20'(tok_code) * 20'd10 + 20'(c - CH_ZERO);
          tok_code = (prod > 20'(CODE_MAX)) ? CODE_MAX : prod[15:0];
        end else begin
          ph = PH_LINE;
        end
      end
      PH_LINE: begin
        if (c == CH_LF) ph = PH_NAME0;
      end
      PH_NAME0: begin
        if (c == CH_LF) begin
          kind = EV_END;
          ph   = PH_DONE;
        end else if (!is_blank(c)) begin
          kind = EV_NSTART;
          ph   = PH_NAME;
        end
      end
      PH_NAME: begin
        if (c == CH_COLON) ph = PH_VALUE0;
        else kind = EV_NBYTE;
      end
      PH_VALUE0: begin
        if (c == CH_LF) begin
          kind  = EV_PAIR;
          empty = 1'b1;
          ph    = PH_NAME0;
        end else if (!is_blank(c)) begin
          kind = EV_VSTART;
          ph   = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (c == CH_LF) begin
          kind = EV_PAIR;
          ph   = PH_NAME0;
        end else if (c == CH_CR) begin
          kind = EV_PAIR;
          ph   = PH_AFTCR;
        end else begin
          kind = EV_VBYTE;
        end
      end
      PH_AFTCR: begin
        if (c == CH_LF) ph = PH_NAME0;
      end
      default: ;
    endcase
    tok_phase       = ph;
    tok.event_kind  = kind;
    tok.byte_out    = (kind == EV_NSTART || kind == EV_NBYTE ||
                       kind == EV_VSTART || kind == EV_VBYTE) ? c : 8'h00;
    tok.value_empty = empty;
    tok.status_code = tok_code;
    tok.header_done = (ph == PH_DONE);
  endtask

  // one line per mismatch, quiet after the first few
  task automatic report(input string what, input int got_v, input int want_v);
    fail_count++;
    if (fail_count <= 30)
      $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h",
               $time, what, got_v, want_v);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    hrt_result_t got;
    hrt_result_t want;
    hrt_result_t tok;
    if (!rst_n) begin
      tok_phase = PH_VER0;
      tok_code  = '0;
      want_tokens.delete();
      fail_count  = 0;
      tokens_owed = 0;
      bytes_seen  = 0;
      pairs_seen  = 0;
      empty_seen  = 0;
      ends_seen   = 0;
      sat_seen    = 0;
    end else begin
      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        got.event_kind  = ev_kind_t'(out_event_kind);
        got.byte_out    = out_byte_out;
        got.value_empty = out_value_empty;
        got.status_code = out_status_code;
        got.header_done = out_header_done;
        bytes_seen++;
        if (got.event_kind == EV_PAIR) pairs_seen++;
        if (got.event_kind == EV_PAIR && got.value_empty) empty_seen++;
        if (got.event_kind == EV_END) ends_seen++;
        if (got.status_code == CODE_MAX) sat_seen++;
        if (want_tokens.size() == 0) begin
          report("result with nothing owed", got.event_kind, 0);
        end else begin
          want = want_tokens.pop_front();
          if (got.event_kind !== want.event_kind)
            report("event_kind", got.event_kind, want.event_kind);
          if (got.byte_out !== want.byte_out)
            report("byte_out", got.byte_out, want.byte_out);
          if (got.value_empty !== want.value_empty)
            report("value_empty", got.value_empty, want.value_empty);
          if (got.status_code !== want.status_code)
            report("status_code", got.status_code, want.status_code);
          if (got.header_done !== want.header_done)
            report("header_done", got.header_done, want.header_done);
        end
      end
      // input transaction feeds the predictor
      if (in_valid && in_ready) begin
        tokenize_byte(in_data_byte, in_new_reply, tok);
        want_tokens.push_back(tok);
      end
      tokens_owed = want_tokens.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the reply header tokenizer: a short warm-up of hand-picked
// bytes, then generated replies (mostly well formed, some cut short, some
// pure noise) with random gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 950;

  // hand-picked opening bytes, {new_reply, data}
  localparam logic [8:0] WARMUP [29] = '{
    {1'b1, CH_SPACE}, {1'b0, 8'h48},    {1'b0, 8'hFF},    {1'b0, CH_SPACE},
    {1'b0, 8'h00},    {1'b0, CH_NINE},  {1'b0, CH_NINE},  {1'b0, CH_NINE},
    {1'b0, CH_NINE},  {1'b0, CH_NINE},  {1'b0, CH_ZERO},  {1'b0, CH_SPACE},
    {1'b0, CH_LF},    {1'b0, CH_TAB},   {1'b0, 8'h41},    {1'b0, CH_CR},
    {1'b0, CH_COLON}, {1'b0, CH_CR},    {1'b0, CH_LF},    {1'b0, 8'hFF},
    {1'b0, CH_COLON}, {1'b0, 8'h76},    {1'b0, 8'h00},    {1'b0, CH_CR},
    {1'b0, 8'h7A},    {1'b0, CH_LF},    {1'b0, CH_LF},    {1'b0, 8'h71},
    {1'b1, 8'h7F}
  };

  typedef struct {
    logic [7:0] b;
    logic       restart;
  } stream_byte_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_new_reply = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_byte_out;
  logic        out_value_empty;
  logic [15:0] out_status_code;
  logic        out_header_done;

  int fail_count, tokens_owed, bytes_seen, pairs_seen, empty_seen, ends_seen, sat_seen;
  int cycles      = 0;
  int stall_left  = 0;
  int random_sent = 0;
  bit calm        = 1'b0;
  bit drained     = 1'b0;

  stream_byte_t reply_q[$];

  http_reply_header_tokenizer dut (.*);

  hrt_token_check reply_check (.*);

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped by watchdog after %0d cycles", cycles);
      $display("[http_reply_header_tokenizer] ERROR");
      $finish;
    end
  end

  // mostly short, now and then long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 99) >= 30) return 0;
    return pick_len();
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    logic ready_nxt;
    ready_nxt = 1'b1;
    if (!rst_n) begin
      ready_nxt = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_nxt = 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = pick_len() - 1;
      ready_nxt  = 1'b0;
    end
    out_ready <= ready_nxt;
  end

  // one input transaction, entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic restart);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_new_reply <= restart;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold the sender off until every owed transaction has arrived
  task automatic wait_until_settled();
    in_valid <= 1'b0;
    do @(negedge clk); while (tokens_owed != 0);
  endtask

  function automatic logic [7:0] pick_ws(input bit no_lf);
    logic [7:0] b;
    do begin
      case ($urandom_range(0, 5))
        0:       b = CH_TAB;
        1:       b = CH_LF;
        2:       b = 8'h0B;
        3:       b = 8'h0C;
        4:       b = CH_CR;
        default: b = CH_SPACE;
      endcase
    end while (no_lf && b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] pick_text(input bit allow_ws, input bit allow_eol,
                                           input bit allow_colon, input bit allow_digit);
    logic [7:0] b;
    bit         bad;
    do begin
      b   = 8'($urandom_range(0, 255));
      bad = (!allow_ws && (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) ||
            (!allow_eol && (b == CH_LF || b == CH_CR)) ||
            (!allow_colon && b == CH_COLON) ||
            (!allow_digit && b >= CH_ZERO && b <= CH_NINE);
    end while (bad);
    return b;
  endfunction

  // the first byte of a reply carries new_reply
  task automatic add_byte(input logic [7:0] b);
    stream_byte_t e;
    e.b       = b;
    e.restart = (reply_q.size() == 0);
    reply_q.push_back(e);
  endtask

  task automatic end_line();
    if ($urandom_range(0, 9) < 6) add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  // a reply with random content, sometimes cut short
  task automatic build_reply();
    int n;
    reply_q.delete();
    repeat ($urandom_range(0, 2)) add_byte(pick_ws(1'b0));
    repeat ($urandom_range(1, 8)) add_byte(pick_text(1'b0, 1'b0, 1'b1, 1'b1));
    add_byte(pick_ws(1'b0));
    // stray non-digits before the code
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) add_byte(pick_text(1'b1, 1'b1, 1'b1, 1'b0));
    n = ($urandom_range(0, 99) < 15) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    repeat (n) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    // reason phrase
    add_byte(($urandom_range(0, 3) != 0) ? CH_SPACE : pick_text(1'b1, 1'b0, 1'b1, 1'b0));
    repeat ($urandom_range(0, 6)) add_byte(pick_text(1'b1, 1'b0, 1'b1, 1'b1));
    end_line();
    // header lines
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 9) == 0) add_byte(pick_ws(1'b1));
      add_byte(pick_text(1'b0, 1'b0, 1'b1, 1'b1));
      repeat ($urandom_range(0, 5))
        add_byte(pick_text(1'b1, $urandom_range(0, 9) == 0, 1'b0, 1'b1));
      add_byte(CH_COLON);
      repeat ($urandom_range(0, 2)) add_byte(pick_ws(1'b1));
      if ($urandom_range(0, 3) == 0) begin
        add_byte(CH_LF);
      end else begin
        add_byte(pick_text(1'b0, 1'b0, 1'b1, 1'b1));
        repeat ($urandom_range(0, 7)) add_byte(pick_text(1'b1, 1'b0, 1'b1, 1'b1));
        end_line();
      end
    end
    end_line();
    // trailing bytes after the blank line
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) add_byte(pick_text(1'b1, 1'b1, 1'b1, 1'b1));
    // broken reply
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, reply_q.size());
      while (reply_q.size() > n) void'(reply_q.pop_back());
    end
  endtask

  // raw noise with the odd restart
  task automatic build_noise();
    stream_byte_t e;
    reply_q.delete();
    repeat ($urandom_range(5, 30)) begin
      e.b       = 8'($urandom_range(0, 255));
      e.restart = ($urandom_range(0, 7) == 0);
      reply_q.push_back(e);
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (WARMUP[i]) push_byte(WARMUP[i][7:0], WARMUP[i][8]);

    while (random_sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_reply();
      foreach (reply_q[i]) push_byte(reply_q[i].b, reply_q[i].restart);
      random_sent += reply_q.size();
      if (!drained && random_sent >= RANDOM_BYTES / 2) begin
        wait_until_settled();
        drained = 1'b1;
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    do @(negedge clk); while (tokens_owed != 0);
    repeat (4) @(negedge clk);

    $display("covered %0d tokenized bytes (%0d generated after the warm-up)",
             bytes_seen, random_sent);
    $display("%0d completed pairs, %0d with empty value, %0d header ends, %0d saturated codes",
             pairs_seen, empty_seen, ends_seen, sat_seen);
    if (fail_count == 0 && tokens_owed == 0) begin
      $display("[http_reply_header_tokenizer] OK");
    end else begin
      $display("[http_reply_header_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
